[rtl/gcm_pkg.sv]
// Shared types and constants for the greedy change maker.
`default_nettype none
package gcm_pkg;

	localparam int unsigned AMT_W  = 24;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned STEP_W = 5;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_COUNT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_DENOM_0 = 3'd1;

	localparam logic [AMT_W-1:0] DENOM_RESET = 24'd1;
	localparam logic [CNT_W-1:0] COUNT_RESET = 3'd1;
	localparam logic [STEP_W-1:0] DIV_LAST   = 5'(AMT_W - 1);

	typedef struct packed {
		logic load_amount;
		logic next_denom;
		logic start_div;
		logic emit_denom;
		logic emit_final;
	} gcm_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic fits;
		logic div_done;
		logic out_free;
	} gcm_status_t;

endpackage
`default_nettype wire

[rtl/gcm_if.sv]
// Channel interfaces: amount in, change results out.
`default_nettype none
interface gcm_in_if;
	logic                       valid;
	logic                       ready;
	logic [gcm_pkg::AMT_W-1:0]  change_amount;

	modport source (output valid, output change_amount, input ready);
	modport sink   (input valid, input change_amount, output ready);
endinterface

interface gcm_out_if;
	logic                       valid;
	logic                       ready;
	logic [gcm_pkg::AMT_W-1:0]  denomination_value;
	logic [gcm_pkg::AMT_W-1:0]  piece_count;
	logic                       is_last;
	logic [gcm_pkg::AMT_W-1:0]  leftover_amount;
	logic                       cannot_pay;

	modport source (output valid, output denomination_value, output piece_count,
		output is_last, output leftover_amount, output cannot_pay, input ready);
	modport sink   (input valid, input denomination_value, input piece_count,
		input is_last, input leftover_amount, input cannot_pay, output ready);
endinterface
`default_nettype wire

[rtl/gcm_dp.sv]
// Datapath: config registers, remainder, restoring divider, output register.
`default_nettype none
module gcm_dp #(
	parameter int unsigned MAX_DENOMS = 7
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [gcm_pkg::IDX_W-1:0]    cfg_idx,
	input  wire logic [gcm_pkg::AMT_W-1:0]    cfg_wdata,
	input  wire logic [gcm_pkg::AMT_W-1:0]    amount_in,
	input  wire gcm_pkg::gcm_cmd_t            cmd,
	output gcm_pkg::gcm_status_t              status,
	gcm_out_if.source                         change
);
	localparam logic [gcm_pkg::CNT_W-1:0] MAX_CNT = gcm_pkg::CNT_W'(MAX_DENOMS);

	logic [gcm_pkg::CNT_W-1:0] count_q;
	logic [gcm_pkg::AMT_W-1:0] denom_q [MAX_DENOMS];
	logic [gcm_pkg::AMT_W-1:0] rem_q;
	logic [gcm_pkg::IDX_W-1:0] idx_q;
	logic [gcm_pkg::AMT_W-1:0] part_q;   // partial remainder
	logic [gcm_pkg::AMT_W-1:0] quo_q;    // dividend shifting out, quotient in
	logic [gcm_pkg::STEP_W-1:0] step_q;
	logic                      busy_q;
	logic                      out_valid_q;

	logic [gcm_pkg::CNT_W-1:0] used;
	logic [gcm_pkg::AMT_W-1:0] d_sel;
	logic [gcm_pkg::AMT_W:0]   shifted;
	logic [gcm_pkg::AMT_W:0]   trial;

	always_comb begin
		d_sel = '0;
		for (int k = 0; k < MAX_DENOMS; k++) begin
			if (idx_q == gcm_pkg::IDX_W'(k)) begin
				d_sel = denom_q[k];
			end
		end
	end

	assign used    = (count_q > MAX_CNT) ? MAX_CNT : count_q;
	assign shifted = {part_q, quo_q[gcm_pkg::AMT_W-1]};
	assign trial   = shifted - {1'b0, d_sel};

	assign status.walk_done = (idx_q >= used);
	assign status.fits      = (d_sel != '0) && (rem_q >= d_sel);
	assign status.div_done  = busy_q && (step_q == gcm_pkg::DIV_LAST);
	assign status.out_free  = !out_valid_q || change.ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= gcm_pkg::COUNT_RESET;
			for (int k = 0; k < MAX_DENOMS; k++) begin
				denom_q[k] <= gcm_pkg::DENOM_RESET;
			end
		end else if (cfg_we) begin
			if (cfg_idx == gcm_pkg::REG_COUNT) begin
				count_q <= cfg_wdata[gcm_pkg::CNT_W-1:0];
			end
			for (int k = 0; k < MAX_DENOMS; k++) begin
				if (cfg_idx == gcm_pkg::REG_DENOM_0 + gcm_pkg::IDX_W'(k)) begin
					denom_q[k] <= cfg_wdata;
				end
			end
		end
	end

	// walk control and divider sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			step_q      <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_amount) begin
				idx_q <= '0;
			end else if (cmd.next_denom || cmd.emit_denom) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.start_div) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == gcm_pkg::DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.emit_denom || cmd.emit_final) begin
				out_valid_q <= 1'b1;
			end else if (change.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_amount) begin
			rem_q <= amount_in;
		end else if (cmd.emit_denom) begin
			rem_q <= part_q;
		end
		if (cmd.start_div) begin
			part_q <= '0;
			quo_q  <= rem_q;
		end else if (busy_q) begin
			if (!trial[gcm_pkg::AMT_W]) begin
				part_q <= trial[gcm_pkg::AMT_W-1:0];
				quo_q  <= {quo_q[gcm_pkg::AMT_W-2:0], 1'b1};
			end else begin
				part_q <= shifted[gcm_pkg::AMT_W-1:0];
				quo_q  <= {quo_q[gcm_pkg::AMT_W-2:0], 1'b0};
			end
		end
		if (cmd.emit_denom) begin
			change.denomination_value <= d_sel;
			change.piece_count        <= quo_q;
			change.is_last            <= 1'b0;
			change.leftover_amount    <= '0;
			change.cannot_pay         <= 1'b0;
		end else if (cmd.emit_final) begin
			change.denomination_value <= '0;
			change.piece_count        <= '0;
			change.is_last            <= 1'b1;
			change.leftover_amount    <= rem_q;
			change.cannot_pay         <= (rem_q != '0);
		end
	end

	assign change.valid = out_valid_q;

endmodule
`default_nettype wire

[rtl/gcm_ctrl.sv]
// Controller: walks the denominations and sequences divide and emit.
`default_nettype none
module gcm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire gcm_pkg::gcm_status_t  status,
	output gcm_pkg::gcm_cmd_t          cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_EMIT,
		S_FINAL
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load_amount = in_valid;
			S_CHECK: begin
				cmd.start_div  = !status.walk_done && status.fits;
				cmd.next_denom = !status.walk_done && !status.fits;
			end
			S_DIV:   ;
			S_EMIT:  cmd.emit_denom = status.out_free;
			S_FINAL: cmd.emit_final = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_CHECK;
				S_CHECK: begin
					if (status.walk_done) begin
						state_q <= S_FINAL;
					end else if (status.fits) begin
						state_q <= S_DIV;
					end
				end
				S_DIV:   if (status.div_done) state_q <= S_EMIT;
				S_EMIT:  if (status.out_free) state_q <= S_CHECK;
				S_FINAL: if (status.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/greedy_change_maker_top.sv]
// Top level of the greedy change maker.
//
//   port     dir    beat contents
//   amount   sink   change_amount
//   change   source denomination_value, piece_count, is_last,
//                   leftover_amount, cannot_pay
//   cfg_*    write  register index, 24-bit data
//
// Each denomination that fits is divided by the 24-step restoring divider;
// a denomination that does not fit is skipped.
// One result register: a new amount is taken while the final beat waits.
// A stalled change port holds the walk in its emit state.
// Reset is asynchronous; config registers return to count 1, values 1.
`default_nettype none
module greedy_change_maker_top #(
	parameter int unsigned MAX_DENOMS = 7
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [gcm_pkg::IDX_W-1:0]  cfg_idx,
	input  wire logic [gcm_pkg::AMT_W-1:0]  cfg_wdata,
	gcm_in_if.sink                          amount,
	gcm_out_if.source                       change
);
	gcm_pkg::gcm_cmd_t    cmd;
	gcm_pkg::gcm_status_t status;

	gcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (amount.valid),
		.in_ready (amount.ready),
		.status   (status),
		.cmd      (cmd)
	);

	gcm_dp #(
		.MAX_DENOMS (MAX_DENOMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.amount_in (amount.change_amount),
		.cmd       (cmd),
		.status    (status),
		.change    (change)
	);

endmodule
`default_nettype wire

[rtl/gcm_checker.sv]
// Port-level checks for the greedy change maker, bound to the top level.
`default_nettype none
module gcm_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [gcm_pkg::AMT_W-1:0] denomination_value,
	input wire logic [gcm_pkg::AMT_W-1:0] piece_count,
	input wire logic                      is_last,
	input wire logic [gcm_pkg::AMT_W-1:0] leftover_amount,
	input wire logic                      cannot_pay
);
	logic [1:0] open_q;   // amounts taken whose last beat has not left yet
	logic       in_beat;
	logic       last_beat;

	assign in_beat   = in_valid && in_ready;
	assign last_beat = out_valid && out_ready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 2'd0;
		end else if (in_beat && !last_beat) begin
			open_q <= open_q + 2'd1;
		end else if (!in_beat && last_beat) begin
			open_q <= open_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(piece_count)
			&& $stable(is_last) && $stable(leftover_amount))
		else $error("change beat dropped or changed while stalled");

	a_denom_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_last |-> denomination_value != '0 && piece_count != '0
			&& leftover_amount == '0 && !cannot_pay)
		else $error("bad denomination beat");

	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> denomination_value == '0 && piece_count == '0
			&& cannot_pay == (leftover_amount != '0))
		else $error("bad final beat");

	// only the final beat of the previous amount may still be waiting
	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> open_q == 2'd0 || (open_q == 2'd1 && out_valid && is_last))
		else $error("new amount taken while previous walk still running");

endmodule

bind greedy_change_maker_top gcm_checker u_gcm_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (amount.valid),
	.in_ready           (amount.ready),
	.out_valid          (change.valid),
	.out_ready          (change.ready),
	.denomination_value (change.denomination_value),
	.piece_count        (change.piece_count),
	.is_last            (change.is_last),
	.leftover_amount    (change.leftover_amount),
	.cannot_pay         (change.cannot_pay)
);
`default_nettype wire
